FILE: rtl/resource_state_barrier_tracker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the resource state barrier tracker.
// These macros expect signals named clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef RESOURCE_STATE_BARRIER_TRACKER_ASSERT_SVH
`define RESOURCE_STATE_BARRIER_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSBT_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("resource state barrier tracker assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RSBT_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("resource state barrier tracker assertion failed");

`endif

FILE: rtl/rsbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsbt_pkg
// Types, codes and helper functions shared by the barrier tracker files.
// ----------------------------------------------------------------------------
package rsbt_pkg;

    localparam int MAX_RESOURCES    = 64;
    localparam int MAX_SUBRESOURCES = 16;
    localparam int RES_W            = 6;
    localparam int SUB_W            = 4;
    localparam int CNT_W            = 5;
    localparam int ST_W             = 8;
    localparam int RC_W             = 7;

    localparam logic [ST_W-1:0] ST_COMMON = 8'h00;
    localparam logic [ST_W-1:0] ST_UAV    = 8'h08;

    localparam logic [2:0] FUNC_BEGIN_PASS = 3'd0;
    localparam logic [2:0] FUNC_ACCESS     = 3'd1;
    localparam logic [2:0] FUNC_ALIAS      = 3'd2;
    localparam logic [2:0] FUNC_DEFINE     = 3'd3;
    localparam logic [2:0] FUNC_QUERY      = 3'd4;

    localparam logic [2:0] KIND_NONE       = 3'd0;
    localparam logic [2:0] KIND_TRANSITION = 3'd1;
    localparam logic [2:0] KIND_UAV        = 3'd2;
    localparam logic [2:0] KIND_ALIAS      = 3'd3;
    localparam logic [2:0] KIND_BAD_SUB    = 3'd4;
    localparam logic [2:0] KIND_FINAL      = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_PROC,
        S_SCAN,
        S_WRITE,
        S_FLUSH
    } rsbt_fsm_t;

    typedef struct packed {
        logic [MAX_SUBRESOURCES-1:0][ST_W-1:0] state;
        logic [MAX_SUBRESOURCES-1:0]           pend;
        logic [CNT_W-1:0]                      cnt;
    } rsbt_row_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [RES_W-1:0] res_id;
        logic             whole_resource;
        logic [SUB_W-1:0] sub_index;
        logic [ST_W-1:0]  state_before;
        logic [ST_W-1:0]  state_after;
        logic             alias_before_present;
        logic             alias_after_present;
        logic             last;
    } rsbt_rec_t;

    function automatic logic [ST_W-1:0] usage_state(input logic [8:0] u);
        logic [ST_W-1:0] s;
        s = ST_COMMON;
        if (u[0])
            s = ST_COMMON;
        else if (u[1])
            s = 8'h01;
        else if (u[2])
            s = 8'h02;
        else if (u[3])
            s = 8'h04;
        else if (u[4])
            s = ST_UAV;
        else
            s = {u[8], u[7], u[6], u[5], 4'h0};
        return s;
    endfunction

    function automatic rsbt_row_t reset_row();
        rsbt_row_t r;
        r.state = '0;
        r.pend  = '0;
        r.cnt   = CNT_W'(1);
        return r;
    endfunction

endpackage

FILE: rtl/rsbt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsbt_req_if / rsbt_rec_if
// Valid/ready channels for requests and barrier records.
// ----------------------------------------------------------------------------
interface rsbt_req_if import rsbt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [2:0]       func;
    logic [RES_W-1:0] resource_id;
    logic             all_subresources;
    logic [SUB_W-1:0] subresource;
    logic [8:0]       usage;
    logic             before_valid;
    logic [RES_W-1:0] before_id;
    logic             after_valid;
    logic [CNT_W-1:0] subresource_count;
    logic [ST_W-1:0]  initial_state;

    modport source (
        output valid, func, resource_id, all_subresources, subresource, usage,
               before_valid, before_id, after_valid, subresource_count, initial_state,
        input  ready
    );
    modport sink (
        input  valid, func, resource_id, all_subresources, subresource, usage,
               before_valid, before_id, after_valid, subresource_count, initial_state,
        output ready
    );
endinterface

interface rsbt_rec_if import rsbt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [2:0]       kind;
    logic [RES_W-1:0] res_id;
    logic             whole_resource;
    logic [SUB_W-1:0] sub_index;
    logic [ST_W-1:0]  state_before;
    logic [ST_W-1:0]  state_after;
    logic             alias_before_present;
    logic             alias_after_present;
    logic             last;

    modport source (
        output valid, kind, res_id, whole_resource, sub_index, state_before, state_after,
               alias_before_present, alias_after_present, last,
        input  ready
    );
    modport sink (
        input  valid, kind, res_id, whole_resource, sub_index, state_before, state_after,
               alias_before_present, alias_after_present, last,
        output ready
    );
endinterface

FILE: rtl/rsbt_row_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsbt_row_ram
// One row per resource: subresource states, pending bits and count.
// ----------------------------------------------------------------------------
module rsbt_row_ram import rsbt_pkg::*; (
    input  logic             clk,
    input  logic             we,
    input  logic [RES_W-1:0] waddr,
    input  rsbt_row_t        wdata,
    input  logic             re,
    input  logic [RES_W-1:0] raddr,
    output rsbt_row_t        rdata
);

    rsbt_row_t mem [MAX_RESOURCES];
    rsbt_row_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/resource_state_barrier_tracker.sv
// ----------------------------------------------------------------------------
// resource_state_barrier_tracker
// Requests are taken one at a time: ready is high only in the idle state.
// Pass, define and access or query requests with ignored ids leave the
// tracker idle; a whole access over mixed states runs the one-row
// read-modify-write loop that walks one subresource per cycle while the
// record output does not stall it.
// Reset: row valid bits clear at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "resource_state_barrier_tracker_assert.svh"

module resource_state_barrier_tracker import rsbt_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    rsbt_req_if.sink        req,
    rsbt_rec_if.source      rec,
    input  logic            cfg_we,
    input  logic [RC_W-1:0] cfg_wdata
);

    rsbt_fsm_t state_reg, state_next;
    logic [RC_W-1:0] cfg_reg;

    logic [2:0]       item_func_reg;
    logic [RES_W-1:0] item_id_reg;
    logic             item_whole_reg;
    logic [SUB_W-1:0] item_sub_reg;
    logic [ST_W-1:0]  item_req_reg;
    logic             item_bvalid_reg;
    logic [RES_W-1:0] item_bid_reg;
    logic             item_avalid_reg;

    rsbt_row_t row_reg, row_next;
    logic [SUB_W-1:0] idx_reg, idx_next;
    logic [MAX_RESOURCES-1:0] row_valid_reg;
    logic [MAX_RESOURCES-1:0] emitted_reg;

    logic      hold_v_reg, hold_v_next;
    rsbt_rec_t hold_reg, hold_next;
    logic      out_v_reg, out_v_next;
    rsbt_rec_t out_reg, out_next;

    logic      accept, req_ok, out_busy, stall;
    logic      gen_v, emit_set, wb_we;
    rsbt_rec_t gen_rec;

    logic             mem_we, mem_re;
    logic [RES_W-1:0] mem_waddr;
    rsbt_row_t        mem_wdata, mem_rdata, def_row;
    logic [CNT_W-1:0] def_cnt;

    logic [ST_W-1:0]  first_st, sub_cur;
    logic [SUB_W-1:0] sel_sub;
    logic             uniform, any_pend, is_uav;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign req_ok   = (cfg_reg > {1'b0, req.resource_id});
    assign out_busy = out_v_reg && !rec.ready;
    assign is_uav   = (item_req_reg == ST_UAV);

    always_comb
    begin
        if (req.subresource_count == '0)
            def_cnt = CNT_W'(1);
        else if (req.subresource_count > CNT_W'(MAX_SUBRESOURCES))
            def_cnt = CNT_W'(MAX_SUBRESOURCES);
        else
            def_cnt = req.subresource_count;
        def_row.state = {MAX_SUBRESOURCES{req.initial_state}};
        def_row.pend  = '0;
        def_row.cnt   = def_cnt;
    end

    assign mem_re    = accept && req_ok &&
                       (req.func == FUNC_ACCESS || req.func == FUNC_QUERY);
    assign mem_we    = (accept && req_ok && req.func == FUNC_DEFINE) || wb_we;
    assign mem_waddr = wb_we ? item_id_reg : req.resource_id;
    assign mem_wdata = wb_we ? row_reg : def_row;

    rsbt_row_ram u_row_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (req.resource_id),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        first_st = row_reg.state[0];
        uniform  = 1'b1;
        any_pend = 1'b0;
        for (int i = 0; i < MAX_SUBRESOURCES; i++)
        begin
            if (CNT_W'(i) < row_reg.cnt)
            begin
                if (row_reg.state[i] != first_st)
                    uniform = 1'b0;
                if (row_reg.pend[i])
                    any_pend = 1'b1;
            end
        end
        sel_sub = (state_reg == S_SCAN) ? idx_reg : item_sub_reg;
        sub_cur = row_reg.state[sel_sub];
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        idx_next   = idx_reg;
        gen_v      = 1'b0;
        gen_rec    = '0;
        emit_set   = 1'b0;
        wb_we      = 1'b0;
        stall      = 1'b0;
        hold_v_next = hold_v_reg;
        hold_next   = hold_reg;
        out_v_next  = out_v_reg && !rec.ready;
        out_next    = out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_ok && (req.func == FUNC_ACCESS || req.func == FUNC_QUERY))
                        state_next = S_LOAD;
                    else if (req.func == FUNC_ALIAS)
                        state_next = S_PROC;
                end
            end
            S_LOAD:
            begin
                row_next   = row_valid_reg[item_id_reg] ? mem_rdata : reset_row();
                state_next = S_PROC;
            end
            S_PROC:
            begin
                gen_rec.res_id = item_id_reg;
                state_next     = S_FLUSH;
                if (item_func_reg == FUNC_ALIAS)
                begin
                    gen_v = 1'b1;
                    gen_rec.kind = KIND_ALIAS;
                    gen_rec.state_before = {2'b00, item_bid_reg};
                    gen_rec.alias_before_present =
                        item_bvalid_reg && (cfg_reg > {1'b0, item_bid_reg});
                    gen_rec.alias_after_present =
                        item_avalid_reg && (cfg_reg > {1'b0, item_id_reg});
                end
                else if (item_func_reg == FUNC_QUERY)
                begin
                    gen_v = 1'b1;
                    gen_rec.kind = KIND_FINAL;
                    gen_rec.state_after = uniform ? first_st : ST_COMMON;
                end
                else if (!item_whole_reg)
                begin
                    if ({1'b0, item_sub_reg} >= row_reg.cnt)
                    begin
                        gen_v = 1'b1;
                        gen_rec.kind = KIND_BAD_SUB;
                        gen_rec.sub_index = item_sub_reg;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                        row_next.pend[sel_sub] = is_uav;
                        row_next.state[sel_sub] = item_req_reg;
                        if (is_uav && sub_cur == ST_UAV && row_reg.pend[sel_sub] &&
                            !emitted_reg[item_id_reg])
                        begin
                            gen_v = 1'b1;
                            emit_set = 1'b1;
                            gen_rec.kind = KIND_UAV;
                        end
                        else if (sub_cur != item_req_reg)
                        begin
                            gen_v = 1'b1;
                            gen_rec.kind = KIND_TRANSITION;
                            gen_rec.sub_index = sel_sub;
                            gen_rec.state_before = sub_cur;
                            gen_rec.state_after = item_req_reg;
                        end
                    end
                end
                else if (uniform)
                begin
                    state_next = S_WRITE;
                    for (int i = 0; i < MAX_SUBRESOURCES; i++)
                    begin
                        if (CNT_W'(i) < row_reg.cnt)
                        begin
                            row_next.pend[i]  = is_uav;
                            row_next.state[i] = item_req_reg;
                        end
                    end
                    if (is_uav && first_st == ST_UAV && any_pend && !emitted_reg[item_id_reg])
                    begin
                        gen_v = 1'b1;
                        emit_set = 1'b1;
                        gen_rec.kind = KIND_UAV;
                    end
                    else if (first_st != item_req_reg)
                    begin
                        gen_v = 1'b1;
                        gen_rec.kind = KIND_TRANSITION;
                        gen_rec.whole_resource = 1'b1;
                        gen_rec.state_before = first_st;
                        gen_rec.state_after = item_req_reg;
                    end
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                gen_rec.res_id = item_id_reg;
                if (is_uav && sub_cur == ST_UAV && row_reg.pend[sel_sub] &&
                    !emitted_reg[item_id_reg])
                begin
                    gen_v = 1'b1;
                    gen_rec.kind = KIND_UAV;
                end
                else if (sub_cur != item_req_reg)
                begin
                    gen_v = 1'b1;
                    gen_rec.kind = KIND_TRANSITION;
                    gen_rec.sub_index = sel_sub;
                    gen_rec.state_before = sub_cur;
                    gen_rec.state_after = item_req_reg;
                end
                stall = gen_v && hold_v_reg && out_busy;
                if (!stall)
                begin
                    emit_set = gen_v && (gen_rec.kind == KIND_UAV);
                    row_next.pend[sel_sub]  = is_uav;
                    row_next.state[sel_sub] = item_req_reg;
                    if ({1'b0, idx_reg} == row_reg.cnt - CNT_W'(1))
                        state_next = S_WRITE;
                    else
                        idx_next = idx_reg + SUB_W'(1);
                end
            end
            S_WRITE:
            begin
                wb_we      = 1'b1;
                state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                if (!hold_v_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_busy)
                begin
                    out_next      = hold_reg;
                    out_next.last = 1'b1;
                    out_v_next    = 1'b1;
                    hold_v_next   = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (gen_v && !stall)
        begin
            if (hold_v_reg)
            begin
                out_next   = hold_reg;
                out_v_next = 1'b1;
            end
            hold_next   = gen_rec;
            hold_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_reg       <= '0;
            row_valid_reg <= '0;
            emitted_reg   <= '0;
            hold_v_reg    <= 1'b0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            hold_v_reg <= hold_v_next;
            out_v_reg  <= out_v_next;
            if (cfg_we)
                cfg_reg <= cfg_wdata;
            if (accept && req_ok && req.func == FUNC_DEFINE)
                row_valid_reg[req.resource_id] <= 1'b1;
            if (wb_we)
                row_valid_reg[item_id_reg] <= 1'b1;
            if (accept && req.func == FUNC_BEGIN_PASS)
                emitted_reg <= '0;
            else if (emit_set)
                emitted_reg[item_id_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        idx_reg  <= idx_next;
        hold_reg <= hold_next;
        out_reg  <= out_next;
        if (accept)
        begin
            item_func_reg   <= req.func;
            item_id_reg     <= req.resource_id;
            item_whole_reg  <= req.all_subresources;
            item_sub_reg    <= req.subresource;
            item_req_reg    <= usage_state(req.usage);
            item_bvalid_reg <= req.before_valid;
            item_bid_reg    <= req.before_id;
            item_avalid_reg <= req.after_valid;
        end
    end

    assign rec.valid                = out_v_reg;
    assign rec.kind                 = out_reg.kind;
    assign rec.res_id               = out_reg.res_id;
    assign rec.whole_resource       = out_reg.whole_resource;
    assign rec.sub_index            = out_reg.sub_index;
    assign rec.state_before         = out_reg.state_before;
    assign rec.state_after          = out_reg.state_after;
    assign rec.alias_before_present = out_reg.alias_before_present;
    assign rec.alias_after_present  = out_reg.alias_after_present;
    assign rec.last                 = out_reg.last;

    `RSBT_ASSERT_IMP(a_idle_hold_empty, state_reg == S_IDLE, !hold_v_reg)
    `RSBT_ASSERT_IMP(a_scan_in_range, state_reg == S_SCAN, {1'b0, idx_reg} < row_reg.cnt)
    `RSBT_ASSERT_NXT(a_uav_marked, emit_set, emitted_reg[item_id_reg])
    `RSBT_ASSERT_NXT(a_write_then_flush, state_reg == S_WRITE, state_reg == S_FLUSH)

endmodule
